@@ rtl/tta_pkg.sv @@
// Shared types, constants and field helpers for the transpose address generator.
package tta_pkg;

   localparam int MAX_RANK  = 6;
   localparam int SIZE_BITS = 10;
   localparam int RANK_W    = 3;
   localparam int SIZES_W   = 60;
   localparam int AXIS_W    = 18;
   localparam int IDX_W     = 32;
   localparam int EB_W      = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_BADCFG = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_IN_RANK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_RANK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IN_SIZES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_SIZES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIS      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ELEM      = 3'd5;

   typedef struct packed {
      logic [RANK_W-1:0]  in_rank;
      logic [RANK_W-1:0]  out_rank;
      logic [SIZES_W-1:0] in_sizes;
      logic [SIZES_W-1:0] out_sizes;
      logic [AXIS_W-1:0]  axis_order;
      logic [EB_W-1:0]    element_bytes;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              cnt_step;
      logic              div_init;
      logic              div_step;
      logic              div_end;
      logic              comp_step;
      logic              comp_final;
      logic              out_ok;
      logic              out_err;
      logic [1:0]        err_code;
      logic [RANK_W-1:0] j;
   } cmd_type;

   typedef struct packed {
      logic bad_cfg;
      logic beyond;
   } stat_type;

   function automatic logic [SIZE_BITS-1:0] size_at(input logic [SIZES_W-1:0] p,
                                                     input logic [RANK_W-1:0] k);
      logic [SIZE_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (k == RANK_W'(i)) r = p[i*SIZE_BITS +: SIZE_BITS];
      end
      return r;
   endfunction

   function automatic logic [2:0] axis_at(input logic [AXIS_W-1:0] p,
                                          input logic [RANK_W-1:0] k);
      logic [2:0] r;
      r = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         if (k == RANK_W'(i)) r = p[i*3 +: 3];
      end
      return r;
   endfunction

endpackage

@@ rtl/tensor_transpose_address_generator_core.sv @@
// Top level: configuration registers, sequencer and datapath of the transpose address generator.
// One request is taken when start is high and busy is low; its result appears on the rsp_
// ports for a single cycle with rsp_valid high and must be taken then, since the receiver
// cannot stall. A good request keeps busy high while the one-bit-per-cycle divider splits the
// index into digits; a bad configuration is answered from the check state and an out-of-range
// index once the element count has been formed.
// The next request may be taken in the cycle its predecessor's result is shown.
// Configuration writes are always ready and must only be made while busy is low.
module tensor_transpose_address_generator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tta_pkg::IDX_W-1:0]         req_output_index,
   output logic                              rsp_valid,
   output logic [tta_pkg::IDX_W-1:0]         rsp_source_index,
   output logic [tta_pkg::IDX_W-1:0]         rsp_source_byte_offset,
   output logic [tta_pkg::IDX_W-1:0]         rsp_dest_byte_offset,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tta_pkg::SIZES_W-1:0]       csr_wdata
);
   import tta_pkg::*;

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_rank       <= RANK_W'(1);
         cfg_ff.out_rank      <= RANK_W'(1);
         cfg_ff.in_sizes      <= SIZES_W'(60'd1127000493261825);
         cfg_ff.out_sizes     <= SIZES_W'(60'd1127000493261825);
         cfg_ff.axis_order    <= AXIS_W'(18'd181896);
         cfg_ff.element_bytes <= EB_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IN_RANK:   cfg_ff.in_rank       <= csr_wdata[RANK_W-1:0];
            REG_OUT_RANK:  cfg_ff.out_rank      <= csr_wdata[RANK_W-1:0];
            REG_IN_SIZES:  cfg_ff.in_sizes      <= csr_wdata;
            REG_OUT_SIZES: cfg_ff.out_sizes     <= csr_wdata;
            REG_AXIS:      cfg_ff.axis_order    <= csr_wdata[AXIS_W-1:0];
            REG_ELEM:      cfg_ff.element_bytes <= csr_wdata[EB_W-1:0];
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   tta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cfg       (cfg_ff),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tta_dp u_dp (
      .clock                  (clock),
      .cfg                    (cfg_ff),
      .cmd                    (cmd),
      .req_output_index       (req_output_index),
      .stat                   (stat),
      .rsp_source_index       (rsp_source_index),
      .rsp_source_byte_offset (rsp_source_byte_offset),
      .rsp_dest_byte_offset   (rsp_dest_byte_offset),
      .rsp_status             (rsp_status)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
      (rsp_source_index == '0 && rsp_source_byte_offset == '0 && rsp_dest_byte_offset == '0))
      else $error("error result carries nonzero fields");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_BADCFG))
      else $error("undefined status code");
`endif

endmodule

@@ rtl/tta_ctrl.sv @@
// Sequencer that steps the datapath through check, count, divide and compose phases.
module tta_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tta_pkg::cfg_type cfg,
   input  tta_pkg::stat_type stat,
   output tta_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_valid
);
   import tta_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_COUNT  = 4'd2;
   localparam logic [3:0] S_TEST   = 4'd3;
   localparam logic [3:0] S_DINIT  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_DEND   = 4'd6;
   localparam logic [3:0] S_COMP   = 4'd7;
   localparam logic [3:0] S_FINAL  = 4'd8;
   localparam logic [3:0] S_SCALE  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [RANK_W-1:0] j_ff, j_in;
   logic [4:0]        bit_ff, bit_in;
   logic              strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      bit_in    = bit_ff;
      cmd       = '0;
      cmd.j     = j_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            j_in = '0;
            if (stat.bad_cfg) begin
               cmd.out_err  = 1'b1;
               cmd.err_code = ST_BADCFG;
               state_in     = S_IDLE;
            end else begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.cnt_step = 1'b1;
            j_in         = j_ff + 1'b1;
            if (j_ff == cfg.out_rank - 1'b1) state_in = S_TEST;
         end
         S_TEST: begin
            j_in = '0;
            if (stat.beyond) begin
               cmd.out_err  = 1'b1;
               cmd.err_code = ST_RANGE;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            bit_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + 1'b1;
            if (bit_ff == 5'd31) state_in = S_DEND;
         end
         S_DEND: begin
            cmd.div_end = 1'b1;
            if (j_ff == cfg.out_rank - 1'b1) begin
               j_in     = cfg.in_rank - 1'b1;
               state_in = (cfg.in_rank == RANK_W'(1)) ? S_FINAL : S_COMP;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_DINIT;
            end
         end
         S_COMP: begin
            cmd.comp_step = 1'b1;
            j_in          = j_ff - 1'b1;
            if (j_ff == RANK_W'(1)) state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.comp_final = 1'b1;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            cmd.out_ok = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      strobe_in = cmd.out_ok | cmd.out_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         j_ff      <= '0;
         bit_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         j_ff      <= j_in;
         bit_ff    <= bit_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = strobe_ff;

endmodule

@@ rtl/tta_dp.sv @@
// Datapath: element count, bit-serial digit divider, index composition and result registers.
module tta_dp (
   input  logic                          clock,
   input  tta_pkg::cfg_type              cfg,
   input  tta_pkg::cmd_type              cmd,
   input  logic [tta_pkg::IDX_W-1:0]     req_output_index,
   output tta_pkg::stat_type             stat,
   output logic [tta_pkg::IDX_W-1:0]     rsp_source_index,
   output logic [tta_pkg::IDX_W-1:0]     rsp_source_byte_offset,
   output logic [tta_pkg::IDX_W-1:0]     rsp_dest_byte_offset,
   output logic [1:0]                    rsp_status
);
   import tta_pkg::*;

   logic [IDX_W-1:0]     oidx_ff, count_ff, rem_ff, dvd_ff, src_ff;
   logic [SIZE_BITS-1:0] part_ff;
   logic [SIZE_BITS-1:0] loc_ff [MAX_RANK];
   logic [IDX_W-1:0]     sidx_ff, sbo_ff, dbo_ff;
   logic [1:0]           status_ff;

   logic [SIZE_BITS-1:0] osz, isz;
   logic [SIZE_BITS:0]   trial;
   logic                 ge;
   logic [SIZE_BITS:0]   diff;
   logic [RANK_W-1:0]    pos;
   logic                 bad_axis;

   always_comb begin
      bad_axis = 1'b0;
      for (int k = 0; k < MAX_RANK; k++) begin
         if (RANK_W'(k) < cfg.out_rank &&
             {1'b0, axis_at(cfg.axis_order, RANK_W'(k))} >= {1'b0, cfg.in_rank})
            bad_axis = 1'b1;
      end
      stat.bad_cfg = (cfg.in_rank == '0) || (cfg.in_rank > RANK_W'(MAX_RANK)) ||
                     (cfg.out_rank == '0) || (cfg.out_rank > cfg.in_rank) || bad_axis;
      stat.beyond  = (oidx_ff >= count_ff);
   end

   assign osz   = size_at(cfg.out_sizes, cmd.j);
   assign isz   = size_at(cfg.in_sizes, cmd.j - 1'b1);
   assign trial = {part_ff, dvd_ff[IDX_W-1]};
   assign ge    = (trial >= {1'b0, osz});
   assign diff  = trial - {1'b0, osz};
   // input position that output digit j lands on
   assign pos   = cfg.in_rank - 1'b1 -
                  axis_at(cfg.axis_order, cfg.out_rank - 1'b1 - cmd.j);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oidx_ff  <= req_output_index;
         count_ff <= IDX_W'(1);
         rem_ff   <= req_output_index;
         src_ff   <= '0;
         for (int k = 0; k < MAX_RANK; k++) loc_ff[k] <= '0;
      end
      if (cmd.cnt_step) count_ff <= IDX_W'(count_ff * osz);
      if (cmd.div_init) begin
         dvd_ff  <= rem_ff;
         part_ff <= '0;
      end
      if (cmd.div_step) begin
         part_ff <= ge ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
         dvd_ff  <= {dvd_ff[IDX_W-2:0], ge};
      end
      if (cmd.div_end && osz != '0) begin
         rem_ff <= dvd_ff;
         if (pos < RANK_W'(MAX_RANK)) loc_ff[pos] <= part_ff;
      end
      if (cmd.comp_step)
         src_ff <= IDX_W'((src_ff + IDX_W'(loc_ff[cmd.j])) * isz);
      if (cmd.comp_final) src_ff <= src_ff + IDX_W'(loc_ff[0]);
      if (cmd.out_ok) begin
         sidx_ff   <= src_ff;
         sbo_ff    <= IDX_W'(src_ff * cfg.element_bytes);
         dbo_ff    <= IDX_W'(oidx_ff * cfg.element_bytes);
         status_ff <= ST_OK;
      end
      if (cmd.out_err) begin
         sidx_ff   <= '0;
         sbo_ff    <= '0;
         dbo_ff    <= '0;
         status_ff <= cmd.err_code;
      end
   end

   assign rsp_source_index       = sidx_ff;
   assign rsp_source_byte_offset = sbo_ff;
   assign rsp_dest_byte_offset   = dbo_ff;
   assign rsp_status             = status_ff;

endmodule
